>>> design/hc20_pkg.sv
// Shared types and constants for the HChaCha20 subkey derivation block.
// No dependencies; used by hc20_cell and hchacha20_subkey_derivation.
package hc20_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned NUM_WORDS = 16;
  localparam int unsigned CFG_INDEX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_3 = 3'd3;

  // The four ChaCha constant words.
  localparam logic [WORD_W-1:0] SIGMA_0 = 32'h6170_7865;
  localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320_646e;
  localparam logic [WORD_W-1:0] SIGMA_2 = 32'h7962_2d32;
  localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6b20_6574;

  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] state_t;

  typedef struct packed {
    logic [63:0] nonce_high;
    logic [63:0] nonce_low;
  } request_t;

  typedef struct packed {
    logic [63:0] subkey_word_3;
    logic [63:0] subkey_word_2;
    logic [63:0] subkey_word_1;
    logic [63:0] subkey_word_0;
  } result_t;

endpackage

>>> design/hc20_cell.sv
// One column round of ChaCha, split over two register stages.
// Depends on hc20_pkg for the state type.
module hc20_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             valid_in,
  input  hc20_pkg::state_t state_in,
  output logic             valid_out,
  output hc20_pkg::state_t state_out
);

  // First half of a quarter round on all four columns: rotations 16 and 12.
  function automatic hc20_pkg::state_t half_first(hc20_pkg::state_t s);
    hc20_pkg::state_t t;
    logic [31:0] a, b, c, d;
    t = s;
    for (int i = 0; i < 4; i++) begin
      a = s[i];
      b = s[4 + i];
      c = s[8 + i];
      d = s[12 + i];
      a = a + b;
      d = d ^ a;
      d = {d[15:0], d[31:16]};
      c = c + d;
      b = b ^ c;
      b = {b[19:0], b[31:20]};
      t[i] = a;
      t[4 + i] = b;
      t[8 + i] = c;
      t[12 + i] = d;
    end
    return t;
  endfunction

  // Second half of a quarter round on all four columns: rotations 8 and 7.
  function automatic hc20_pkg::state_t half_second(hc20_pkg::state_t s);
    hc20_pkg::state_t t;
    logic [31:0] a, b, c, d;
    t = s;
    for (int i = 0; i < 4; i++) begin
      a = s[i];
      b = s[4 + i];
      c = s[8 + i];
      d = s[12 + i];
      a = a + b;
      d = d ^ a;
      d = {d[23:0], d[31:24]};
      c = c + d;
      b = b ^ c;
      b = {b[24:0], b[31:25]};
      t[i] = a;
      t[4 + i] = b;
      t[8 + i] = c;
      t[12 + i] = d;
    end
    return t;
  endfunction

  logic             mid_valid;
  hc20_pkg::state_t mid_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      valid_out <= 1'b0;
    end else begin
      mid_valid <= valid_in;
      valid_out <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    mid_state <= half_first(state_in);
    state_out <= half_second(mid_state);
  end

endmodule

>>> design/hchacha20_subkey_derivation.sv
// Top level of the HChaCha20 subkey derivation block.
// Depends on hc20_pkg and instantiates a chain of hc20_cell rounds.
//
// Usage:
// The 256-bit key is written through the configuration channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data) as four 64-bit words, index 0 to 3; a
// write to any other index is ignored. cfg_ready is always high. The key
// must only be changed while no request is in flight.
// A request carries a 128-bit nonce and is accepted on a clock edge where
// start is high and busy is low. busy is never raised, so one request can
// be accepted in every cycle.
// Each request yields one result, shown on the result port for exactly one
// cycle with done high. Each round is one cell of two register stages, a
// double round is two cells, and an output register follows the last cell.
// Throughput is one request per cycle, set by the fully unrolled cell chain.
// Results leave in the order the requests arrived. The receiver cannot
// stall the block, so no buffering is needed beyond the pipeline itself.
// Synchronous reset clears the key to zero and drops every request in
// flight; no clearing pass is needed.
module hchacha20_subkey_derivation #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  hc20_pkg::request_t                  request,
  output logic                                done,
  output hc20_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hc20_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [63:0]                         cfg_data
);

  // Each cell performs one round; even cells act on columns, odd cells on
  // diagonals after the rows have been rotated into column positions.
  localparam int unsigned NUM_CELLS = 2 * DOUBLE_ROUNDS;

  logic [63:0] key_word_0;
  logic [63:0] key_word_1;
  logic [63:0] key_word_2;
  logic [63:0] key_word_3;

  hc20_pkg::state_t init_state;
  logic             accept;

  logic             cell_valid_in  [NUM_CELLS];
  hc20_pkg::state_t cell_state_in  [NUM_CELLS];
  logic             cell_valid_out [NUM_CELLS];
  hc20_pkg::state_t cell_state_out [NUM_CELLS];
  hc20_pkg::state_t final_state;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Key registers; a write to an unknown index has no effect.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_word_0 <= '0;
      key_word_1 <= '0;
      key_word_2 <= '0;
      key_word_3 <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hc20_pkg::REG_KEY_WORD_0: key_word_0 <= cfg_data;
        hc20_pkg::REG_KEY_WORD_1: key_word_1 <= cfg_data;
        hc20_pkg::REG_KEY_WORD_2: key_word_2 <= cfg_data;
        hc20_pkg::REG_KEY_WORD_3: key_word_3 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Initial state: constants, key and nonce, each 64-bit word split with
  // its low half in the lower-numbered state word.
  always_comb begin
    init_state[0]  = hc20_pkg::SIGMA_0;
    init_state[1]  = hc20_pkg::SIGMA_1;
    init_state[2]  = hc20_pkg::SIGMA_2;
    init_state[3]  = hc20_pkg::SIGMA_3;
    init_state[4]  = key_word_0[31:0];
    init_state[5]  = key_word_0[63:32];
    init_state[6]  = key_word_1[31:0];
    init_state[7]  = key_word_1[63:32];
    init_state[8]  = key_word_2[31:0];
    init_state[9]  = key_word_2[63:32];
    init_state[10] = key_word_3[31:0];
    init_state[11] = key_word_3[63:32];
    init_state[12] = request.nonce_low[31:0];
    init_state[13] = request.nonce_low[63:32];
    init_state[14] = request.nonce_high[31:0];
    init_state[15] = request.nonce_high[63:32];
  end

  assign cell_valid_in[0] = accept;
  assign cell_state_in[0] = init_state;

  // Between cells the rows are rotated: after a column round, row r moves
  // left by r words so the diagonals line up as columns; after a diagonal
  // round the rotation is undone.
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    hc20_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (cell_valid_in[k]),
      .state_in  (cell_state_in[k]),
      .valid_out (cell_valid_out[k]),
      .state_out (cell_state_out[k])
    );

    if (k + 1 < NUM_CELLS) begin : g_link
      assign cell_valid_in[k + 1] = cell_valid_out[k];
      for (genvar r = 0; r < 4; r++) begin : g_row
        for (genvar c = 0; c < 4; c++) begin : g_col
          if (k % 2 == 0) begin : g_diag
            assign cell_state_in[k + 1][r * 4 + c] =
              cell_state_out[k][r * 4 + ((c + r) % 4)];
          end else begin : g_undiag
            assign cell_state_in[k + 1][r * 4 + c] =
              cell_state_out[k][r * 4 + ((c + 4 - r) % 4)];
          end
        end
      end
    end
  end

  // The last cell is a diagonal round; bring the rows back home.
  for (genvar r = 0; r < 4; r++) begin : g_final_row
    for (genvar c = 0; c < 4; c++) begin : g_final_col
      assign final_state[r * 4 + c] =
        cell_state_out[NUM_CELLS - 1][r * 4 + ((c + 4 - r) % 4)];
    end
  end

  // Output register: the result is shown for one cycle with done high.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cell_valid_out[NUM_CELLS - 1];
    end
  end

  always_ff @(posedge clk) begin
    result.subkey_word_0 <= {final_state[1], final_state[0]};
    result.subkey_word_1 <= {final_state[3], final_state[2]};
    result.subkey_word_2 <= {final_state[13], final_state[12]};
    result.subkey_word_3 <= {final_state[15], final_state[14]};
  end

endmodule

>>> tb/sv/hchacha20_subkey_derivation_tb.sv
// Self-checking testbench for the HChaCha20 subkey derivation block.
// Depends on hc20_pkg and hchacha20_subkey_derivation, which in turn needs hc20_cell.
// An in-bench predictor computes every subkey, which is compared field by field.
module hchacha20_subkey_derivation_tb;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [hc20_pkg::CFG_INDEX_W-1:0] cfg_index_t;

  localparam int unsigned DOUBLE_ROUNDS = 10;
  // Pipeline depth as stated at the head of the block: two stages per round
  // plus the output register.
  localparam int unsigned LATENCY = 4 * DOUBLE_ROUNDS + 1;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned REQUESTS_PER_PHASE = 200;
  localparam int unsigned REPORT_LIMIT = 10;
  // Indexes past the last key register are not mapped; writes there must be dropped.
  localparam cfg_index_t REG_UNMAPPED_FIRST = hc20_pkg::REG_KEY_WORD_3 + 1'b1;
  localparam cfg_index_t REG_UNMAPPED_LAST = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  hc20_pkg::request_t request = '0;
  logic done;
  hc20_pkg::result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_index_t cfg_index = hc20_pkg::REG_KEY_WORD_0;
  logic [63:0] cfg_data = '0;

  // Nonces waiting to be issued, and the subkeys that accepted requests must produce.
  hc20_pkg::request_t nonce_queue[$];
  hc20_pkg::result_t subkey_expect[$];

  // The bench's own copy of the four key registers, tracking every accepted write.
  logic [63:0] key_copy[4];

  // Percentage chance that the driver opens an idle burst; zero means back-to-back.
  int unsigned idle_pct = 0;
  int unsigned requests_sent = 0;
  int unsigned subkeys_checked = 0;
  int unsigned key_writes = 0;
  int unsigned mismatch_count = 0;

  hchacha20_subkey_derivation #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // One ChaCha quarter round; the four words come back in the order given.
  function automatic logic [127:0] mix_quarter(input logic [31:0] a, input logic [31:0] b,
                                               input logic [31:0] c, input logic [31:0] d);
    a = a + b; d = rotl32(d ^ a, 16);
    c = c + d; b = rotl32(b ^ c, 12);
    a = a + b; d = rotl32(d ^ a, 8);
    c = c + d; b = rotl32(b ^ c, 7);
    return {a, b, c, d};
  endfunction

  // Builds the working array from the constants, the current key and the nonce,
  // runs the double rounds and picks out words 0..3 and 12..15. There is no
  // feed-forward addition, unlike the ChaCha block function.
  function automatic hc20_pkg::result_t derive_subkey(input hc20_pkg::request_t nonce);
    logic [31:0] w[16];
    hc20_pkg::result_t subkey;
    w[0] = hc20_pkg::SIGMA_0;
    w[1] = hc20_pkg::SIGMA_1;
    w[2] = hc20_pkg::SIGMA_2;
    w[3] = hc20_pkg::SIGMA_3;
    for (int k = 0; k < 4; k++) begin
      w[4 + 2 * k] = key_copy[k][31:0];
      w[5 + 2 * k] = key_copy[k][63:32];
    end
    w[12] = nonce.nonce_low[31:0];
    w[13] = nonce.nonce_low[63:32];
    w[14] = nonce.nonce_high[31:0];
    w[15] = nonce.nonce_high[63:32];
    for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
      // Column rounds.
      {w[0], w[4], w[8], w[12]} = mix_quarter(w[0], w[4], w[8], w[12]);
      {w[1], w[5], w[9], w[13]} = mix_quarter(w[1], w[5], w[9], w[13]);
      {w[2], w[6], w[10], w[14]} = mix_quarter(w[2], w[6], w[10], w[14]);
      {w[3], w[7], w[11], w[15]} = mix_quarter(w[3], w[7], w[11], w[15]);
      // Diagonal rounds.
      {w[0], w[5], w[10], w[15]} = mix_quarter(w[0], w[5], w[10], w[15]);
      {w[1], w[6], w[11], w[12]} = mix_quarter(w[1], w[6], w[11], w[12]);
      {w[2], w[7], w[8], w[13]} = mix_quarter(w[2], w[7], w[8], w[13]);
      {w[3], w[4], w[9], w[14]} = mix_quarter(w[3], w[4], w[9], w[14]);
    end
    subkey.subkey_word_0 = {w[1], w[0]};
    subkey.subkey_word_1 = {w[3], w[2]};
    subkey.subkey_word_2 = {w[13], w[12]};
    subkey.subkey_word_3 = {w[15], w[14]};
    return subkey;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------
  // Everything is driven with nonblocking assignments at the rising edge, so the
  // block never samples a value at the edge that sets it. start gets exactly
  // one assignment per edge: the decision is made in a local flag first.
  always @(posedge clk) begin : request_driver
    logic issue;
    int unsigned gap_left;
    if (rst) begin
      gap_left = 0;
      start <= 1'b0;
    end else begin
      // A request is taken at this edge when start was high and busy low.
      if (start && !busy) begin
        subkey_expect.push_back(derive_subkey(request));
        void'(nonce_queue.pop_front());
        requests_sent++;
      end
      if (start && busy) begin
        // Held off: keep the same request on the port.
        issue = 1'b1;
      end else begin
        issue = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (nonce_queue.size() != 0) begin
          if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            // This cycle is the first of an idle burst.
            gap_left = $urandom_range(7);
          end else begin
            issue = 1'b1;
            request <= nonce_queue[0];
          end
        end
      end
      start <= issue;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  // done lasts exactly one cycle and cannot be held off, so every edge with done
  // high consumes the oldest expected subkey.
  always @(posedge clk) begin : subkey_monitor
    hc20_pkg::result_t want;
    if (!rst && done) begin
      if (subkey_expect.size() == 0) begin
        report_mismatch("subkey with no request outstanding, word 0", '0,
                        result.subkey_word_0);
      end else begin
        want = subkey_expect.pop_front();
        subkeys_checked++;
        for (int f = 0; f < 4; f++) begin
          if (result[f * 64 +: 64] !== want[f * 64 +: 64]) begin
            report_mismatch($sformatf("subkey %0d, subkey_word_%0d", subkeys_checked, f),
                            want[f * 64 +: 64], result[f * 64 +: 64]);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and phase control
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly random nonce halves, with the occasional all-zero, all-one or
  // single-bit value mixed in.
  function automatic logic [63:0] nonce_half();
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(63);
      default: return rand64();
    endcase
  endfunction

  function automatic hc20_pkg::request_t make_nonce(input logic [63:0] high,
                                                    input logic [63:0] low);
    return hc20_pkg::request_t'{nonce_high: high, nonce_low: low};
  endfunction

  // Holds cfg_valid high for back-to-back writes; the caller lowers it once
  // the last write has gone through, so valid never gets two updates in a step.
  task automatic write_key_reg(input cfg_index_t index, input logic [63:0] data);
    cfg_index <= index;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    key_writes++;
    case (index)
      hc20_pkg::REG_KEY_WORD_0: key_copy[0] = data;
      hc20_pkg::REG_KEY_WORD_1: key_copy[1] = data;
      hc20_pkg::REG_KEY_WORD_2: key_copy[2] = data;
      hc20_pkg::REG_KEY_WORD_3: key_copy[3] = data;
      default: ; // unmapped index, the block drops the write
    endcase
  endtask

  task automatic write_full_key(input logic [63:0] k0, input logic [63:0] k1,
                                input logic [63:0] k2, input logic [63:0] k3);
    write_key_reg(hc20_pkg::REG_KEY_WORD_0, k0);
    write_key_reg(hc20_pkg::REG_KEY_WORD_1, k1);
    write_key_reg(hc20_pkg::REG_KEY_WORD_2, k2);
    write_key_reg(hc20_pkg::REG_KEY_WORD_3, k3);
    cfg_valid <= 1'b0;
  endtask

  // Returns once every queued request has been taken and every subkey checked.
  // Each request yields a subkey, so at that point the pipeline is empty and
  // the key may be rewritten.
  task automatic wait_drained();
    while (nonce_queue.size() != 0 || subkey_expect.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [63:0] key_val[4];
    for (int k = 0; k < 4; k++) key_copy[k] = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Key straight out of reset is all zeros.
    idle_pct = 0;
    nonce_queue.push_back(make_nonce('0, '0));
    nonce_queue.push_back(make_nonce('1, '1));
    wait_drained();

    // Published HChaCha20 vector key (bytes 00..1f) followed by a write to an
    // unmapped index, which must leave the key untouched.
    write_key_reg(hc20_pkg::REG_KEY_WORD_0, 64'h0706_0504_0302_0100);
    write_key_reg(hc20_pkg::REG_KEY_WORD_1, 64'h0f0e_0d0c_0b0a_0908);
    write_key_reg(hc20_pkg::REG_KEY_WORD_2, 64'h1716_1514_1312_1110);
    write_key_reg(hc20_pkg::REG_KEY_WORD_3, 64'h1f1e_1d1c_1b1a_1918);
    write_key_reg(REG_UNMAPPED_FIRST, rand64());
    write_key_reg(REG_UNMAPPED_LAST, '1);
    cfg_valid <= 1'b0;
    nonce_queue.push_back(make_nonce(64'h2759_4131_0000_0000, 64'h4a00_0000_0900_0000));
    nonce_queue.push_back(make_nonce('0, '0));
    nonce_queue.push_back(make_nonce('1, '1));
    nonce_queue.push_back(make_nonce('0, '1));
    nonce_queue.push_back(make_nonce('1, '0));
    nonce_queue.push_back(make_nonce({16{4'h5}}, {16{4'ha}}));
    nonce_queue.push_back(make_nonce({16{4'ha}}, {16{4'h5}}));
    nonce_queue.push_back(make_nonce(64'h8000_0000_0000_0000, 64'h1));
    nonce_queue.push_back(make_nonce(64'h1, 64'h8000_0000_0000_0000));
    wait_drained();

    // All-ones key.
    write_full_key('1, '1, '1, '1);
    nonce_queue.push_back(make_nonce('0, '0));
    nonce_queue.push_back(make_nonce('1, '1));
    nonce_queue.push_back(make_nonce(rand64(), rand64()));
    wait_drained();

    // Alternating key pattern, with gaps between requests.
    idle_pct = 50;
    write_full_key({16{4'h5}}, {16{4'ha}}, {16{4'h5}}, {16{4'ha}});
    for (int i = 0; i < 4; i++) nonce_queue.push_back(make_nonce(rand64(), rand64()));
    wait_drained();

    // Random phases. The first two use the extreme keys, the rest rewrite a
    // random subset of the registers, sometimes with a stray unmapped write.
    // The last phase runs with no idling at all.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      for (int k = 0; k < 4; k++) begin
        if (p == 0) key_val[k] = '0;
        else if (p == 1) key_val[k] = '1;
        else key_val[k] = ($urandom_range(7) == 0) ? nonce_half() : rand64();
      end
      if (p < 2) begin
        write_full_key(key_val[0], key_val[1], key_val[2], key_val[3]);
      end else begin
        write_key_reg(hc20_pkg::REG_KEY_WORD_0, key_val[0]);
        if ($urandom_range(3) != 0) write_key_reg(hc20_pkg::REG_KEY_WORD_1, key_val[1]);
        if ($urandom_range(3) != 0) write_key_reg(hc20_pkg::REG_KEY_WORD_2, key_val[2]);
        if ($urandom_range(3) != 0) write_key_reg(hc20_pkg::REG_KEY_WORD_3, key_val[3]);
        if ($urandom_range(1) != 0) begin
          write_key_reg(cfg_index_t'($urandom_range(REG_UNMAPPED_FIRST, REG_UNMAPPED_LAST)),
                        rand64());
        end
        cfg_valid <= 1'b0;
      end
      if (p == RANDOM_PHASES - 1) idle_pct = 0;
      else idle_pct = (p % 3 == 0) ? 5 : ((p % 3 == 1) ? 20 : 45);
      for (int i = 0; i < REQUESTS_PER_PHASE; i++) begin
        nonce_queue.push_back(make_nonce(nonce_half(), nonce_half()));
      end
      wait_drained();
    end

    // Let the pipeline run empty so that any stray extra subkey shows up.
    repeat (LATENCY + 8) @(posedge clk);
    if (subkey_expect.size() != 0) mismatch_count += subkey_expect.size();

    $display("Issued %0d nonces and checked %0d subkeys over %0d key register writes,",
             requests_sent, subkeys_checked, key_writes);
    $display("covering reset, extreme and random keys, unmapped writes and idle bursts.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Far above the slowest legal run: about 1650 requests with the longest
  // idle bursts plus one pipeline drain per phase.
  initial begin : watchdog
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
design/hc20_pkg.sv
design/hc20_cell.sv
design/hchacha20_subkey_derivation.sv
tb/sv/hchacha20_subkey_derivation_tb.sv
